[hw/rtl/cack_pkg.sv]
package cack_pkg;

    localparam int ACK_DEPTH = 62;
    localparam int CNT_W     = $clog2(ACK_DEPTH + 1);
    localparam int ADDR_W    = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1;

    localparam logic [7:0] MARKER_RESET = 8'hE8;
    localparam logic [7:0] TYPE_META    = 8'd0;
    localparam logic [7:0] TYPE_DATA    = 8'd1;

    localparam logic [11:0] LEN_MIN_HDR  = 12'd63;
    localparam logic [11:0] LEN_MIN_META = 12'd66;
    localparam logic [11:0] LEN_MIN_IDX  = 12'd64;
    localparam logic [11:0] LEN_PAYLOAD_BASE = 12'd62;

    localparam logic [1:0] VERDICT_PASS = 2'd0;
    localparam logic [1:0] VERDICT_DROP = 2'd1;
    localparam logic [1:0] VERDICT_TX   = 2'd2;

    localparam logic [1:0] HOST_NONE = 2'd0;
    localparam logic [1:0] HOST_META = 2'd1;
    localparam logic [1:0] HOST_DATA = 2'd2;

    // frame classification
    localparam logic [2:0] CL_PASS  = 3'd0;
    localparam logic [2:0] CL_META  = 3'd1;
    localparam logic [2:0] CL_DELIV = 3'd2;
    localparam logic [2:0] CL_DROP  = 3'd3;
    localparam logic [2:0] CL_FLUSH = 3'd4;

    typedef struct packed {
        logic [11:0] frame_length;
        logic [7:0]  marker_byte;
        logic [7:0]  type_byte;
        logic [7:0]  field_one;
        logic [7:0]  field_two;
        logic [7:0]  field_three;
    } t_in_item;

    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] host_msg;
        logic [7:0] host_len;
        logic       is_ack_byte;
        logic [7:0] ack_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic load_first;
        logic load_cnt;
        logic load_entry;
    } t_cmd;

    typedef struct packed {
        logic [2:0] cls;
        logic       out_free;
        logic       thr_zero;
        logic       idx_last;
    } t_sts;

endpackage

[hw/rtl/cack_in_if.sv]
interface cack_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] frame_length;
    logic [7:0]  marker_byte;
    logic [7:0]  type_byte;
    logic [7:0]  field_one;
    logic [7:0]  field_two;
    logic [7:0]  field_three;

    modport source (output valid, frame_length, marker_byte, type_byte,
                    field_one, field_two, field_three, input ready);
    modport sink   (input valid, frame_length, marker_byte, type_byte,
                    field_one, field_two, field_three, output ready);
endinterface

[hw/rtl/cack_out_if.sv]
interface cack_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [1:0] host_msg;
    logic [7:0] host_len;
    logic       is_ack_byte;
    logic [7:0] ack_byte;
    logic       last;

    modport source (output valid, verdict, host_msg, host_len, is_ack_byte,
                    ack_byte, last, input ready);
    modport sink   (input valid, verdict, host_msg, host_len, is_ack_byte,
                    ack_byte, last, output ready);
endinterface

[hw/rtl/cumulative_ack_receiver.sv]
// Cumulative ack receiver: classifies one received frame header per request.
// i_in carries the header fields of a frame; o_out carries the result
// requests. Pass, deliver, drop and metadata frames give one result with last set.
// A data frame that fills the list to the threshold gives a transmit result,
// then the count byte, then one result for each of the first threshold entries;
// only the final one has last set, and the list count clears.
// i_cfg_we with i_cfg_wdata writes the expected sender marker.
// The accepted header is registered, and the first result is registered from it
// once the output is free. The block takes one frame at a time and accepts
// the next only after the last result of the frame is loaded. A flush sends
// threshold + 1 ack bytes, paced by the single read port of the ack list.
// Reset sets the marker to 0xE8 and clears payload size, threshold and
// count; the list memory is not cleared and needs no clearing pass.
// A stalled o_out holds its result; the block loads no new result until the
// receiver takes it, though a new frame can still be accepted while idle.
module cumulative_ack_receiver
    import cack_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    cack_in_if.sink    i_in,
    cack_out_if.source o_out
);

    t_cmd      cmd;
    t_sts      sts;
    t_in_item  item;
    t_out_item res;
    logic      out_valid;
    logic      in_ready;

    assign item.frame_length = i_in.frame_length;
    assign item.marker_byte  = i_in.marker_byte;
    assign item.type_byte    = i_in.type_byte;
    assign item.field_one    = i_in.field_one;
    assign item.field_two    = i_in.field_two;
    assign item.field_three  = i_in.field_three;
    assign i_in.ready        = in_ready;

    cack_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cack_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_out       (res),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    assign o_out.valid       = out_valid;
    assign o_out.verdict     = res.verdict;
    assign o_out.host_msg    = res.host_msg;
    assign o_out.host_len    = res.host_len;
    assign o_out.is_ack_byte = res.is_ack_byte;
    assign o_out.ack_byte    = res.ack_byte;
    assign o_out.last        = res.last;

endmodule

[hw/rtl/cack_ctrl.sv]
module cack_ctrl
    import cack_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_CNT  = 2'd2;
    localparam logic [1:0] S_LIST = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.out_free) begin
                    o_cmd.load_first = 1'b1;
                    n_state = (i_sts.cls == CL_FLUSH) ? S_CNT : S_IDLE;
                end
            end
            S_CNT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_cnt = 1'b1;
                    n_state = i_sts.thr_zero ? S_IDLE : S_LIST;
                end
            end
            S_LIST: begin
                if (i_sts.out_free) begin
                    o_cmd.load_entry = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[hw/rtl/cack_dpath.sv]
module cack_dpath
    import cack_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  t_in_item  i_item,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  t_cmd      i_cmd,
    output t_sts      o_sts
);

    logic [7:0]       r_marker;
    logic [7:0]       r_payload_size;
    logic [CNT_W-1:0] r_thr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    t_in_item         r_item;
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic [7:0]       ack_mem [ACK_DEPTH];
    logic [7:0]       r_rd_data;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic             wr_en;

    logic [7:0]       n_len;
    logic [11:0]      need_len;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] thr_sat;
    logic [2:0]       cls;
    logic             any_load;

    always_comb begin
        n_len    = r_payload_size + 8'd2;
        need_len = LEN_PAYLOAD_BASE + {4'd0, n_len};
        cnt_inc  = r_count + CNT_W'(1);
        if ({24'd0, r_item.field_three} > 32'(ACK_DEPTH)) begin
            thr_sat = CNT_W'(ACK_DEPTH);
        end else begin
            thr_sat = CNT_W'(r_item.field_three);
        end

        priority if (r_item.frame_length < LEN_MIN_HDR || r_item.marker_byte != r_marker) begin
            cls = CL_PASS;
        end else if (r_item.type_byte == TYPE_META) begin
            cls = (r_item.frame_length < LEN_MIN_META) ? CL_PASS : CL_META;
        end else if (r_item.type_byte != TYPE_DATA) begin
            cls = CL_PASS;
        end else if (n_len != 8'd0 && r_item.frame_length < need_len) begin
            cls = CL_PASS;
        end else if (r_count >= CNT_W'(ACK_DEPTH) ||
                     r_item.frame_length < LEN_MIN_IDX) begin
            cls = CL_DELIV;
        end else if (cnt_inc < r_thr) begin
            cls = CL_DROP;
        end else begin
            cls = CL_FLUSH;
        end
    end

    assign o_sts.cls      = cls;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.thr_zero = (r_thr == '0);
    assign o_sts.idx_last = ((r_idx + CNT_W'(1)) == r_thr);

    assign wr_en    = i_cmd.load_first && (cls == CL_DROP || cls == CL_FLUSH);
    // count byte goes out with the read of entry 0; each entry fetches the next
    assign rd_en    = i_cmd.load_cnt || (i_cmd.load_entry && !o_sts.idx_last);
    assign rd_addr  = i_cmd.load_cnt ? '0 : ADDR_W'(r_idx + CNT_W'(1));
    assign any_load = i_cmd.load_first || i_cmd.load_cnt || i_cmd.load_entry;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            ack_mem[r_count[ADDR_W-1:0]] <= r_item.field_one;
        end
        if (rd_en) begin
            r_rd_data <= ack_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker       <= MARKER_RESET;
            r_payload_size <= '0;
            r_thr          <= '0;
            r_count        <= '0;
            r_idx          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_marker <= i_cfg_wdata;
            end
            if (i_cmd.load_first) begin
                if (cls == CL_META) begin
                    r_payload_size <= r_item.field_two;
                    r_thr          <= thr_sat;
                end
                if (cls == CL_DROP || cls == CL_FLUSH) begin
                    r_count <= cnt_inc;
                end
            end
            if (i_cmd.load_cnt) begin
                r_count <= '0;
                r_idx   <= '0;
            end
            if (i_cmd.load_entry) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (any_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_out = '0;
        if (i_cmd.load_first) begin
            n_out.last = 1'b1;
            unique case (cls)
                CL_META: begin
                    n_out.verdict  = VERDICT_TX;
                    n_out.host_msg = HOST_META;
                end
                CL_DELIV: begin
                    n_out.host_msg = HOST_DATA;
                    n_out.host_len = n_len;
                end
                CL_DROP: begin
                    n_out.verdict  = VERDICT_DROP;
                    n_out.host_msg = HOST_DATA;
                    n_out.host_len = n_len;
                end
                CL_FLUSH: begin
                    n_out.verdict  = VERDICT_TX;
                    n_out.host_msg = HOST_DATA;
                    n_out.host_len = n_len;
                    n_out.last     = 1'b0;
                end
                default: n_out.verdict = VERDICT_PASS;
            endcase
        end else if (i_cmd.load_cnt) begin
            n_out.verdict     = VERDICT_TX;
            n_out.is_ack_byte = 1'b1;
            n_out.ack_byte    = 8'(r_count);
            n_out.last        = o_sts.thr_zero;
        end else if (i_cmd.load_entry) begin
            n_out.verdict     = VERDICT_TX;
            n_out.is_ack_byte = 1'b1;
            n_out.ack_byte    = r_rd_data;
            n_out.last        = o_sts.idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (any_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[tb/cumulative_ack_receiver_tb.sv]
module cumulative_ack_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cack_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_SLACK    = 4;
    localparam int HOLD_OFF_LEN   = 300;
    localparam logic [11:0] LEN_MIN_MARKER = 12'd10;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    cack_in_if  in_if();
    cack_out_if out_if();

    cumulative_ack_receiver DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // shadow of the receiver state
    logic [7:0]  marker_reg;
    logic [7:0]  pay_size;
    logic [7:0]  ack_thr;
    int unsigned ack_cnt;
    logic [7:0]  ack_entries [ACK_DEPTH];
    t_out_item   expected_q [$];

    int err_cnt;
    int quiet_cycles;
    bit tx_idle_en;
    bit rx_stall_en;
    int rx_hold_len;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_in_item make_frame(input logic [11:0] len, input logic [7:0] mk,
                                            input logic [7:0] typ, input logic [7:0] a,
                                            input logic [7:0] b, input logic [7:0] c);
        make_frame = {len, mk, typ, a, b, c};
    endfunction

    function automatic void push_result(input logic [1:0] verdict, input logic [1:0] msg,
                                        input logic [7:0] len, input logic is_ack,
                                        input logic [7:0] ab, input logic last);
        t_out_item r;
        r.verdict     = verdict;
        r.host_msg    = msg;
        r.host_len    = len;
        r.is_ack_byte = is_ack;
        r.ack_byte    = ab;
        r.last        = last;
        expected_q.push_back(r);
    endfunction

    function automatic void predict_frame(input t_in_item f);
        logic [7:0]  n;
        int unsigned i;
        n = pay_size + 8'd2;
        if (f.frame_length < LEN_MIN_MARKER || f.marker_byte != marker_reg ||
            f.frame_length < LEN_MIN_HDR) begin
            push_result(VERDICT_PASS, HOST_NONE, 8'd0, 1'b0, 8'd0, 1'b1);
            return;
        end
        if (f.type_byte == TYPE_META) begin
            if (f.frame_length < LEN_MIN_META) begin
                push_result(VERDICT_PASS, HOST_NONE, 8'd0, 1'b0, 8'd0, 1'b1);
            end else begin
                pay_size = f.field_two;
                ack_thr  = (f.field_three > ACK_DEPTH) ? 8'(ACK_DEPTH) : f.field_three;
                push_result(VERDICT_TX, HOST_META, 8'd0, 1'b0, 8'd0, 1'b1);
            end
            return;
        end
        if (f.type_byte != TYPE_DATA) begin
            push_result(VERDICT_PASS, HOST_NONE, 8'd0, 1'b0, 8'd0, 1'b1);
            return;
        end
        if (n != 8'd0 && int'(f.frame_length) < int'(LEN_PAYLOAD_BASE) + int'(n)) begin
            push_result(VERDICT_PASS, HOST_NONE, 8'd0, 1'b0, 8'd0, 1'b1);
            return;
        end
        // delivered, but no room or no index byte
        if (ack_cnt >= ACK_DEPTH || f.frame_length < LEN_MIN_IDX) begin
            push_result(VERDICT_PASS, HOST_DATA, n, 1'b0, 8'd0, 1'b1);
            return;
        end
        ack_entries[ack_cnt] = f.field_one;
        ack_cnt++;
        if (ack_cnt < ack_thr) begin
            push_result(VERDICT_DROP, HOST_DATA, n, 1'b0, 8'd0, 1'b1);
            return;
        end
        push_result(VERDICT_TX, HOST_DATA, n, 1'b0, 8'd0, 1'b0);
        push_result(VERDICT_TX, HOST_NONE, 8'd0, 1'b1, 8'(ack_cnt), ack_thr == 8'd0);
        // a lowered threshold sends only the first ack_thr entries
        for (i = 0; i < ack_thr; i++) begin
            push_result(VERDICT_TX, HOST_NONE, 8'd0, 1'b1, ack_entries[i], (i + 1) == ack_thr);
        end
        ack_cnt = 0;
    endfunction

    function automatic string show(input t_out_item r);
        return $sformatf("verdict=%0d host=%0d len=%0d ack=%0b/%0d last=%0b", r.verdict,
                         r.host_msg, r.host_len, r.is_ack_byte, r.ack_byte, r.last);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_frame(input t_in_item f);
        if (tx_idle_en && $urandom_range(99) < 7) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.frame_length <= f.frame_length;
        in_if.marker_byte  <= f.marker_byte;
        in_if.type_byte    <= f.type_byte;
        in_if.field_one    <= f.field_one;
        in_if.field_two    <= f.field_two;
        in_if.field_three  <= f.field_three;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predict_frame(f);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    task automatic write_marker(input logic [7:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        marker_reg = value;
    endtask

    // metadata request followed by data requests; broken_pct of them malformed
    task automatic send_ack_sequence(input logic [7:0] pay, input logic [7:0] thr,
                                     input int n_data, input int broken_pct);
        t_in_item f;
        int       min_len;
        int       k;
        send_frame(make_frame(12'($urandom_range(66, 4095)), marker_reg, TYPE_META,
                              8'($urandom), pay, thr));
        for (k = 0; k < n_data; k++) begin
            min_len = int'(LEN_PAYLOAD_BASE) + int'(8'(pay_size + 8'd2));
            if (min_len < int'(LEN_MIN_IDX)) min_len = int'(LEN_MIN_IDX);
            f = make_frame(12'($urandom_range(min_len, 4095)), marker_reg, TYPE_DATA,
                           8'($urandom), 8'($urandom), 8'($urandom));
            if ($urandom_range(99) < broken_pct) begin
                case ($urandom_range(2))
                    0: f.frame_length = 12'($urandom_range(0, 4095));
                    1: f.marker_byte  = marker_reg ^ (8'd1 << $urandom_range(7));
                    default: f.type_byte = 8'($urandom);
                endcase
            end
            send_frame(f);
        end
    endtask

    task automatic test_header_checks();
        send_frame(make_frame(12'd0, 8'h00, TYPE_META, 8'h00, 8'h00, 8'h00));
        send_frame(make_frame(12'd9, MARKER_RESET, TYPE_DATA, 8'h01, 8'h02, 8'h03));
        send_frame(make_frame(12'd62, MARKER_RESET, TYPE_META, 8'h00, 8'h10, 8'h02));
        send_frame(make_frame(12'd4095, MARKER_RESET ^ 8'h01, TYPE_META, 8'h00, 8'h10, 8'h02));
        send_frame(make_frame(12'd4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        // short metadata must not touch the stored settings
        send_frame(make_frame(12'd63, MARKER_RESET, TYPE_META, 8'h00, 8'h40, 8'h05));
        send_frame(make_frame(12'd65, MARKER_RESET, TYPE_META, 8'h00, 8'h40, 8'h05));
        send_frame(make_frame(12'd4095, MARKER_RESET, 8'd2, 8'h11, 8'h22, 8'h33));
        send_frame(make_frame(12'd100, MARKER_RESET, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        drain();
    endtask

    task automatic test_ack_flushing();
        // zero threshold: a data request that is not too short flushes with the count alone
        send_frame(make_frame(12'd66, MARKER_RESET, TYPE_META, 8'h00, 8'h00, 8'h00));
        send_frame(make_frame(12'd63, MARKER_RESET, TYPE_DATA, 8'h77, 8'h00, 8'h00));
        send_frame(make_frame(12'd64, MARKER_RESET, TYPE_DATA, 8'hA5, 8'h00, 8'h00));
        // zero-length payload, threshold saturates
        send_frame(make_frame(12'd4095, MARKER_RESET, TYPE_META, 8'hFF, 8'd254, 8'hFF));
        send_frame(make_frame(12'd63, MARKER_RESET, TYPE_DATA, 8'h12, 8'h00, 8'h00));
        send_frame(make_frame(12'd64, MARKER_RESET, TYPE_DATA, 8'h34, 8'h00, 8'h00));
        send_frame(make_frame(12'd66, MARKER_RESET, TYPE_META, 8'h00, 8'hFF, 8'd3));
        send_frame(make_frame(12'd63, MARKER_RESET, TYPE_DATA, 8'h56, 8'h00, 8'h00));
        send_frame(make_frame(12'd100, MARKER_RESET, TYPE_DATA, 8'h00, 8'h00, 8'h00));
        send_frame(make_frame(12'd100, MARKER_RESET, TYPE_DATA, 8'hFF, 8'h00, 8'h00));
        send_frame(make_frame(12'd200, MARKER_RESET, TYPE_DATA, 8'h5A, 8'h00, 8'h00));
        // payload longer than the request
        send_frame(make_frame(12'd66, MARKER_RESET, TYPE_META, 8'h00, 8'd100, 8'd4));
        send_frame(make_frame(12'd163, MARKER_RESET, TYPE_DATA, 8'h01, 8'h00, 8'h00));
        send_frame(make_frame(12'd164, MARKER_RESET, TYPE_DATA, 8'h02, 8'h00, 8'h00));
        send_frame(make_frame(12'd164, MARKER_RESET, TYPE_DATA, 8'h03, 8'h00, 8'h00));
        send_frame(make_frame(12'd164, MARKER_RESET, TYPE_DATA, 8'h04, 8'h00, 8'h00));
        // threshold dropped below the count
        send_frame(make_frame(12'd66, MARKER_RESET, TYPE_META, 8'h00, 8'h00, 8'd1));
        send_frame(make_frame(12'd64, MARKER_RESET, TYPE_DATA, 8'hC3, 8'h00, 8'h00));
        drain();
    endtask

    task automatic test_marker_register();
        write_marker(8'h00);
        send_frame(make_frame(12'd100, 8'h00, TYPE_META, 8'h00, 8'd5, 8'd2));
        send_frame(make_frame(12'd100, 8'hFF, TYPE_DATA, 8'h9A, 8'h00, 8'h00));
        send_frame(make_frame(12'd100, 8'h00, TYPE_DATA, 8'h9B, 8'h00, 8'h00));
        write_marker(8'hFF);
        send_frame(make_frame(12'd4095, 8'hFF, TYPE_DATA, 8'h3C, 8'h00, 8'h00));
        send_frame(make_frame(12'd4095, 8'h00, TYPE_DATA, 8'h3D, 8'h00, 8'h00));
        drain();
    endtask

    task automatic test_receiver_backpressure();
        int k;
        send_frame(make_frame(12'd300, marker_reg, TYPE_META, 8'h00, 8'd10, 8'd3));
        drain();
        tx_idle_en  = 1'b0;
        rx_hold_len = HOLD_OFF_LEN;
        for (k = 0; k < 12; k++) begin
            send_frame(make_frame(12'd200, marker_reg, TYPE_DATA, 8'(k), 8'h00, 8'h00));
        end
        drain();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_longest_flush();
        send_ack_sequence(8'($urandom_range(0, 200)), 8'(ACK_DEPTH), ACK_DEPTH, 0);
        drain();
    endtask

    task automatic run_random_phase(input int n_items);
        int         sent;
        int         thr;
        int         burst;
        logic [7:0] pay;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 20) begin
                send_frame(make_frame(
                    ($urandom_range(1) != 0) ? 12'($urandom) : 12'($urandom_range(0, 70)),
                    ($urandom_range(1) != 0) ? marker_reg : 8'($urandom),
                    ($urandom_range(99) < 40) ? 8'($urandom) : 8'($urandom_range(0, 2)),
                    8'($urandom), 8'($urandom), 8'($urandom)));
                sent++;
            end else begin
                pay   = ($urandom_range(99) < 10) ? 8'($urandom_range(254, 255)) : 8'($urandom);
                thr   = ($urandom_range(99) < 5) ? $urandom_range(62, 255) : $urandom_range(0, 6);
                burst = $urandom_range(1, ((thr > ACK_DEPTH) ? ACK_DEPTH : thr) + 2);
                send_ack_sequence(pay, 8'(thr), burst, 10);
                sent += burst + 1;
            end
            if ($urandom_range(99) < 3) drain();
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 4; phase++) begin
            write_marker((phase % 2 == 0) ? 8'($urandom) : MARKER_RESET);
            // one phase runs without any idling on either side
            tx_idle_en  = (phase != 2);
            rx_stall_en = (phase != 2);
            run_random_phase(60);
        end
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // result receiver: random stalls plus requested hold-offs
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                out_if.ready <= 1'b0;
                repeat (rx_hold_len) @(negedge i_clk);
                rx_hold_len = 0;
            end
            out_if.ready <= !(rx_stall_en && $urandom_range(99) < 7);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.verdict, out_if.host_msg, out_if.host_len, out_if.is_ack_byte,
                   out_if.ack_byte, out_if.last};
            if (expected_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result, expected none, got %s", $time, show(got));
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    $display("%0t: result mismatch, expected %s, got %s", $time,
                             show(want), show(got));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = 8'h00;
        in_if.valid        = 1'b0;
        in_if.frame_length = 12'd0;
        in_if.marker_byte  = 8'h00;
        in_if.type_byte    = 8'h00;
        in_if.field_one    = 8'h00;
        in_if.field_two    = 8'h00;
        in_if.field_three  = 8'h00;
        marker_reg   = MARKER_RESET;
        pay_size     = 8'd0;
        ack_thr      = 8'd0;
        ack_cnt      = 0;
        err_cnt      = 0;
        quiet_cycles = 0;
        tx_idle_en   = 1'b1;
        rx_stall_en  = 1'b1;
        rx_hold_len  = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_header_checks();
        test_ack_flushing();
        test_marker_register();
        test_receiver_backpressure();
        test_longest_flush();
        test_random_traffic();

        drain();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[cumulative_ack_receiver.f]
hw/rtl/cack_pkg.sv
hw/rtl/cack_in_if.sv
hw/rtl/cack_out_if.sv
hw/rtl/cack_ctrl.sv
hw/rtl/cack_dpath.sv
hw/rtl/cumulative_ack_receiver.sv
tb/cumulative_ack_receiver_tb.sv
